[hw/rtl/sct_pkg.sv]
// sct_pkg: shared types and constants for the session close timer sweep
// used by sct_ctrl, sct_datapath and session_close_timer_sweep
// no dependencies
package sct_pkg;

   // table geometry
   localparam int SESSION_COUNT = 1024;
   localparam int PTR_W         = $clog2(SESSION_COUNT);

   // field widths
   localparam int SID_W       = 10;
   localparam int TIMER_W     = 32;
   localparam int ENTRY_W     = TIMER_W + 1;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   // request kind codes, carried on req_tuser
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic clear_wr;    // clearing pass: write empty entry at pointer
      logic set_wr;      // load timer of requested session
      logic tick_rd;     // read entry under the sweep pointer
      logic upd_dec;     // write back decremented timer
      logic upd_release; // deactivate entry and load result register
      logic ptr_adv;     // advance sweep pointer
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic ptr_last;  // pointer sits on the last entry
      logic rd_active; // entry read has its active flag set
      logic rd_zero;   // entry read has an expired timer
      logic out_free;  // result register can take a new result this cycle
   } status_type;

endpackage

[hw/rtl/sct_ram.sv]
// sct_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sct_datapath.sv]
// sct_datapath: timer table, sweep pointer, timeout register and result register
// depends on sct_pkg and sct_ram
module sct_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  sct_pkg::cmd_type                 cmd,
   output sct_pkg::status_type              status,
   input  logic [sct_pkg::SID_W-1:0]        req_session_id,
   input  logic                             csr_wr_en,
   input  logic [sct_pkg::TIMER_W-1:0]      csr_wr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sct_pkg::SID_W-1:0]        rsp_released_session
);
   import sct_pkg::*;

   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [TIMER_W-1:0] timeout_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SID_W-1:0]   rsp_sid_ff;

   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic               rd_active;
   logic [TIMER_W-1:0] rd_timer;
   logic               sid_in_range;

   // entry layout: active flag on top of the timer
   assign rd_active = rd_data[ENTRY_W-1];
   assign rd_timer  = rd_data[TIMER_W-1:0];

   assign sid_in_range = 32'(req_session_id) < 32'(SESSION_COUNT);

   // table write port selection
   always_comb begin
      wr_en   = cmd.clear_wr | (cmd.set_wr & sid_in_range) | cmd.upd_dec | cmd.upd_release;
      wr_addr = ptr_ff;
      wr_data = '0;
      if (cmd.set_wr) begin
         wr_addr = PTR_W'(req_session_id);
         wr_data = {1'b1, timeout_ff};
      end else if (cmd.upd_dec) begin
         wr_data = {1'b1, rd_timer - TIMER_W'(1)};
      end else if (cmd.upd_release) begin
         wr_data = {1'b0, rd_timer};
      end
   end

   sct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SESSION_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.tick_rd),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // sweep pointer wraps after the last entry
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_adv) begin
         ptr_in = status.ptr_last ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   // result register, freed by a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.upd_release) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         timeout_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.upd_release) begin
         rsp_sid_ff <= SID_W'(ptr_ff);
      end
   end

   // status to controller
   assign status.ptr_last  = ptr_ff == PTR_W'(SESSION_COUNT - 1);
   assign status.rd_active = rd_active;
   assign status.rd_zero   = rd_timer == '0;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_released_session = rsp_sid_ff;

   // a result appears only after a release command
   a_rsp_from_release: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.upd_release))
      else $error("result valid without release");

   // pointer moves only when commanded
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.ptr_adv |=> $stable(ptr_ff))
      else $error("sweep pointer moved without command");

   // release never overwrites a pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_release |-> (!rsp_valid_ff || rsp_tready))
      else $error("release while result register occupied");

endmodule

[hw/rtl/sct_ctrl.sv]
// sct_ctrl: state machine for clearing pass, set and sweep tick sequencing
// depends on sct_pkg
module sct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_kind,
   input  sct_pkg::status_type status,
   output sct_pkg::cmd_type    cmd
);
   import sct_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      req_accept;

   assign req_accept = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.ptr_adv  = 1'b1;
            if (status.ptr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_SET) begin
                  cmd.set_wr = 1'b1;
               end else begin
                  cmd.tick_rd = 1'b1;
                  state_in    = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            // entry under the pointer is on the ram read port
            if (!status.rd_active) begin
               cmd.ptr_adv = 1'b1;
               state_in    = ST_IDLE;
            end else if (!status.rd_zero) begin
               cmd.upd_dec = 1'b1;
               cmd.ptr_adv = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.out_free) begin
               cmd.upd_release = 1'b1;
               cmd.ptr_adv     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a tick blocks further transfers until its write-back is done
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_TICK) |=> !req_tready)
      else $error("request taken during tick write-back");

   // at most one table write per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.set_wr, cmd.upd_dec, cmd.upd_release}))
      else $error("conflicting table writes");

   // release only when the result register can take it
   a_release_free: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_release |-> status.out_free)
      else $error("release with result register busy");

endmodule

[hw/rtl/session_close_timer_sweep.sv]
// session_close_timer_sweep: top level, per-session close timers with a sweep pointer
// depends on sct_pkg, sct_ctrl, sct_datapath (and sct_ram through the datapath)
//
//   channel   ports          content
//   req       req_t*         tuser: kind; tdata: session_id
//   rsp       rsp_t*         tdata: released_session
//   csr       csr_wr_*       timeout_ticks, written when csr_wr_en is high
//
// a set request is a single table write; a sweep tick is a read of the
// timer table followed by a write-back, since the table's read port is registered.
// after reset a clearing pass over all SESSION_COUNT (1024) entries empties the table;
// no request is taken then, csr writes are.
// a finished result waits in the result register; requests are still taken,
// and only a tick that expires an entry stalls until that register is free.
module session_close_timer_sweep (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sct_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [9:0] session_id
   input  logic                                req_tuser,  // [0] kind
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sct_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [9:0] released_session
   // configuration
   input  logic                                csr_wr_en,
   input  logic [sct_pkg::TIMER_W-1:0]         csr_wr_data
);
   import sct_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [SID_W-1:0] released_session;

   sct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   sct_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_session_id       (req_tdata[SID_W-1:0]),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_released_session (released_session)
   );

   // pad result to whole bytes
   assign rsp_tdata = RSP_TDATA_W'(released_session);

endmodule
